// File: sv/tmr_pkg.sv
`default_nettype none

package tmr_pkg;

  // Frame kinds carried on every character of a frame.
  localparam logic [1:0] KIND_READING = 2'd0;
  localparam logic [1:0] KIND_HIGH    = 2'd1;
  localparam logic [1:0] KIND_LOW     = 2'd2;
  localparam logic [1:0] KIND_ZERO    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE        = 2'd0;
  localparam logic [1:0] REG_REPORT_PERIOD = 2'd1;
  localparam logic [1:0] REG_HIGH_LIMIT    = 2'd2;
  localparam logic [1:0] REG_LOW_LIMIT     = 2'd3;

  // Frame characters.
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_H    = 8'h68;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam int FRAME_LEN_SHORT   = 4;
  localparam int FRAME_LEN_READING = 7;

  // Settings the front end needs from the register file.
  typedef struct packed {
    logic       enable;
    logic [7:0] threshold;
    logic [9:0] high_limit;
    logic [9:0] low_limit;
  } cfg_t;

  // One classified report waiting for the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] d_hun;
    logic [3:0] d_ten;
    logic [3:0] d_one;
  } report_t;

  localparam int REPORT_W = $bits(report_t);

endpackage

`default_nettype wire

// File: sv/tmr_front.sv
`default_nettype none

module tmr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmr_pkg::cfg_t     cfg,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [15:0]       in_tdata,
  input  wire logic              q_full,
  output      logic              q_push,
  output      tmr_pkg::report_t  q_data
);

  logic [7:0]  tick_count_r;
  logic [7:0]  tick_count_nxt;
  logic [7:0]  tick_inc;
  logic        accept;
  logic        due;
  logic [9:0]  temp;
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [6:0]  rem;
  logic [14:0] ten_prod;
  logic [3:0]  ten;
  logic [3:0]  one;
  logic [1:0]  kind;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign tick_inc = (tick_count_r == 8'hFF) ? tick_count_r : tick_count_r + 8'd1;
  assign due      = (tick_inc >= cfg.threshold);

  always_comb begin
    tick_count_nxt = tick_count_r;
    if (accept && cfg.enable) begin
      tick_count_nxt = due ? 8'd0 : tick_inc;
    end
  end

  // Temperature is sample / 64; digits by reciprocal multiplies, exact for 0..1023.
  assign temp     = in_tdata[15:6];
  assign hun_prod = 16'(temp) * 16'd41;
  assign hun      = hun_prod[15:12];
  assign rem      = 7'(temp - (10'(hun) * 10'd100));
  assign ten_prod = 15'(rem) * 15'd205;
  assign ten      = ten_prod[14:11];
  assign one      = 4'(rem - (7'(ten) * 7'd10));

  always_comb begin
    if (in_tdata == 16'd0) begin
      kind = tmr_pkg::KIND_ZERO;
    end else if (temp > cfg.high_limit) begin
      kind = tmr_pkg::KIND_HIGH;
    end else if (temp < cfg.low_limit) begin
      kind = tmr_pkg::KIND_LOW;
    end else begin
      kind = tmr_pkg::KIND_READING;
    end
  end

  assign q_push       = accept && cfg.enable && due;
  assign q_data.kind  = kind;
  assign q_data.d_hun = hun;
  assign q_data.d_ten = ten;
  assign q_data.d_one = one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= 8'd0;
    end else begin
      tick_count_r <= tick_count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/tmr_fifo.sv
`default_nettype none

module tmr_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tmr_pkg::report_t  push_data,
  output      logic              full,
  input  wire logic              pop,
  output      logic              not_empty,
  output      tmr_pkg::report_t  pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tmr_pkg::report_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("report queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("report queue read while empty");

endmodule

`default_nettype wire

// File: sv/tmr_back.sv
`default_nettype none

module tmr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire tmr_pkg::report_t  q_data,
  output      logic              q_pop,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [7:0]        out_tdata,
  output      logic [1:0]        out_tuser,
  output      logic              out_tlast
);

  logic             active_r;
  logic             active_nxt;
  logic [2:0]       pos_r;
  logic [2:0]       pos_nxt;
  tmr_pkg::report_t cur_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_kind_r;
  logic             out_last_r;
  logic             load_out;
  logic             emit;
  logic             short_frame;
  logic [7:0]       ch;
  logic             ch_last;

  assign short_frame = (cur_r.kind != tmr_pkg::KIND_READING);

  always_comb begin
    unique case (pos_r)
      3'd0: ch = tmr_pkg::CH_S;
      3'd1: ch = !short_frame ? tmr_pkg::CH_T :
                 (cur_r.kind == tmr_pkg::KIND_HIGH) ? tmr_pkg::CH_H : tmr_pkg::CH_L;
      3'd2: ch = tmr_pkg::CH_ZERO;
      3'd3: ch = short_frame ? tmr_pkg::CH_E : tmr_pkg::CH_ZERO + 8'(cur_r.d_hun);
      3'd4: ch = tmr_pkg::CH_ZERO + 8'(cur_r.d_ten);
      3'd5: ch = tmr_pkg::CH_ZERO + 8'(cur_r.d_one);
      default: ch = tmr_pkg::CH_E;
    endcase
  end

  assign ch_last = short_frame ? (pos_r == 3'(tmr_pkg::FRAME_LEN_SHORT - 1))
                               : (pos_r == 3'(tmr_pkg::FRAME_LEN_READING - 1));

  assign load_out = !out_valid_r || out_tready;
  assign emit     = active_r && load_out;
  // The next report is taken in the same cycle the closing character is loaded into the output register.
  assign q_pop    = q_valid && (!active_r || (emit && ch_last));

  always_comb begin
    active_nxt    = active_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_r + 3'd1;
      if (ch_last) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      pos_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      out_byte_r <= ch;
      out_kind_r <= cur_r.kind;
      out_last_r <= ch_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_short_len : assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && short_frame) |-> (pos_r < 3'(tmr_pkg::FRAME_LEN_SHORT)))
    else $error("short frame ran past its closing character");

  a_last_is_e : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == tmr_pkg::CH_E))
    else $error("frame closed on a character other than e");

  a_frame_start : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (active_r && pos_r == 3'd0))
    else $error("new frame did not start at its first character");

endmodule

`default_nettype wire

// File: sv/threshold_temperature_reporter.sv
// Threshold temperature reporter. Each input item is one timer tick carrying a 16-bit raw ADC
// sample. While enabled, the tick counter counts ticks; when it reaches report_period/5 it
// clears and the sample is reported as an ASCII frame, one character per output item:
// "sl0e" for a zero sample, "sh0e" above high_limit, "sl0e" below low_limit, and otherwise
// "st0" plus three digit characters of the temperature (sample/64) and "e". tuser carries
// the frame kind and tlast marks the closing "e". A reporting tick is classified in the cycle
// it is accepted and placed in a small report queue; the back end then sends one character
// per cycle while out_tready is high, so a frame is 4 or 7 characters long, and a new frame
// follows the previous one without a gap when its report is already queued. Sustained
// throughput of reporting ticks is therefore set by the one-character-per-cycle output
// stage; the queue (QUEUE_DEPTH entries) lets the input keep accepting ticks while a frame
// drains. Configuration writes take effect at once and are meant to happen only while no
// frame is pending.
`default_nettype none

module threshold_temperature_reporter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  // Tick input.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  // Frame character output.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,  // [7:0] frame_byte
  output      logic [1:0]  out_tuser,  // [1:0] frame_kind
  output      logic        out_tlast
);

  // Register file. The report period is stored already divided by five, since only the
  // tick threshold is ever used; p*205>>10 equals p/5 for every 10-bit p.
  logic        enable_r;
  logic [7:0]  threshold_r;
  logic [9:0]  high_limit_r;
  logic [9:0]  low_limit_r;
  logic [17:0] period_prod;

  assign period_prod = 18'(cfg_wdata) * 18'd205;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      threshold_r  <= 8'd2;
      high_limit_r <= 10'd500;
      low_limit_r  <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        tmr_pkg::REG_ENABLE:        enable_r     <= cfg_wdata[0];
        tmr_pkg::REG_REPORT_PERIOD: threshold_r  <= period_prod[17:10];
        tmr_pkg::REG_HIGH_LIMIT:    high_limit_r <= cfg_wdata;
        tmr_pkg::REG_LOW_LIMIT:     low_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tmr_pkg::cfg_t    cfg;
  tmr_pkg::report_t push_data;
  tmr_pkg::report_t pop_data;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;

  assign cfg.enable     = enable_r;
  assign cfg.threshold  = threshold_r;
  assign cfg.high_limit = high_limit_r;
  assign cfg.low_limit  = low_limit_r;

  // Front end: tick counting, classification and digit split.
  tmr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // Report queue between the two halves.
  tmr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Back end: character sequencer with a registered output.
  tmr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
